/* rtl/core/lspg_pkg.sv */
// Shared types and constants of the LED strip pattern pixel generator.
// Holds the request and result structs, mode and register codes and the
// restoring divide step used by the pipeline; no dependencies.
package lspg_pkg;

  // Pattern modes
  localparam logic [2:0] MODE_STATIC  = 3'd0;
  localparam logic [2:0] MODE_RAINBOW = 3'd1;
  localparam logic [2:0] MODE_CHASE   = 3'd2;
  localparam logic [2:0] MODE_FADE    = 3'd3;
  localparam logic [2:0] MODE_WAVE    = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_COUNT      = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;
  localparam logic [1:0] REG_FILL       = 2'd3;

  localparam logic [10:0] PIXELS_MAX = 11'd1024;

  // Reciprocal and phase step constants
  localparam logic [63:0] RECIP_DIV10  = 64'h00000000CCCCCCCD;
  localparam logic [63:0] RECIP_DIV50  = 64'h0000000051EB851F;
  localparam logic [63:0] FADE_STEP    = 64'd13671306;
  localparam logic [63:0] WAVE_STEP_T  = 64'd34178264;
  localparam logic [63:0] WAVE_STEP_X  = 64'd341782638;

  // Bits of dividend retired per divide stage, and number of stages
  localparam int DIV_STEPS  = 7;
  localparam int DIV_STAGES = 4;

  typedef struct packed {
    logic [31:0] elapsed_ms;
    logic [9:0]  pixel_index;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
    logic [7:0] level;
  } pixel_out_t;

  // Partial state of a restoring division
  typedef struct packed {
    logic [11:0] rem;
    logic [7:0]  quo;
  } div_t;

  // Scaled sine values for fade level and wave color
  typedef struct packed {
    logic [7:0] lvl;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } wave_t;

  // Retire seven dividend bits, MSB first.
  function automatic div_t div_steps(div_t s, logic [6:0] bits, logic [11:0] d);
    div_t        r;
    logic [12:0] t;
    r = s;
    for (int j = 6; j >= 0; j--) begin
      t = {r.rem, bits[j]};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        r.quo = {r.quo[6:0], 1'b1};
      end else begin
        r.quo = {r.quo[6:0], 1'b0};
      end
      r.rem = t[11:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/led_strip_pattern_pixel_generator_core.sv */
// Top level of the LED strip pattern pixel generator: a six-stage pipeline
// from pixel request to RGBW color and level. Depends on lspg_pkg.

// One pixel request is taken every clock unless the output stalls. A stage
// loads when it is empty or its successor loads, so a stall at the output
// holds full stages up to a gap, nothing is dropped or repeated, and gaps fill up
// regardless. Stage one runs the reciprocal multiplies for elapsed/10 and
// elapsed/50 and the phase products; the next four stages run the two
// restoring divisions (pixel spacing for the rainbow hue and the chase
// position modulo twice the count) seven bits per stage, and alongside them
// form the sine table index, read the SINE_ENTRIES-deep sine table into a
// register and scale the sine. The last stage picks the color by mode and
// blanks pixels beyond the strip. Write configuration only while no request
// is in flight; a write takes effect at the next clock.
module led_strip_pattern_pixel_generator_core #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lspg_pkg::pixel_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lspg_pkg::pixel_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import lspg_pkg::*;

  localparam int IdxW = $clog2(SINE_ENTRIES);
  localparam int NStg = 6;

  typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

  // Scale a Q30 product back down, truncating toward zero.
  function automatic longint q30_trunc(longint x);
    return (x < 0) ? -((-x) >>> 30) : (x >>> 30);
  endfunction

  // Build the Q1.15 sine table from the quarter-wave odd polynomial.
  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] f64;
    logic [63:0] num, rq;
    logic [31:0] f;
    logic [1:0]  quad;
    longint      w, u, u2, acc, s, q;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      // Turn fraction of entry k: (k << 32) over the table depth
      num = 64'(k) << 32;
      rq  = '0;
      f64 = '0;
      for (int b = 63; b >= 0; b--) begin
        rq = {rq[62:0], num[b]};
        if (rq >= 64'(SINE_ENTRIES)) begin
          rq     = rq - 64'(SINE_ENTRIES);
          f64[b] = 1'b1;
        end
      end
      f    = f64[31:0];
      quad = f[31:30];
      w    = longint'({34'd0, f[29:0]});
      u    = quad[0] ? ((longint'(1) << 30) - w) : w;
      u2   = (u * u) >>> 30;
      acc  = 64'sd172272;
      acc  = -64'sd5026995   + q30_trunc(acc * u2);
      acc  = 64'sd85569306   + q30_trunc(acc * u2);
      acc  = -64'sd693598668 + q30_trunc(acc * u2);
      acc  = 64'sd1686629713 + q30_trunc(acc * u2);
      s    = q30_trunc(acc * u);
      if (s < 0) s = 0;
      q = (s + 16384) >>> 15;
      if (q > 32767) q = 32767;
      rom[k] = quad[1] ? 16'(-q) : 16'(q);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Configuration
  logic [2:0]  pattern_mode_q;
  logic [10:0] pixel_count_q;
  logic [7:0]  user_brightness_q;
  logic [31:0] fill_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_mode_q    <= MODE_STATIC;
      pixel_count_q     <= 11'd1;
      user_brightness_q <= 8'd255;
      fill_color_q      <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:       pattern_mode_q    <= cfg_data_i[2:0];
        REG_COUNT:      pixel_count_q     <= cfg_data_i[10:0];
        REG_BRIGHTNESS: user_brightness_q <= cfg_data_i[7:0];
        REG_FILL:       fill_color_q      <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Saturate the count; the chase wraps at twice the count.
  logic [10:0] cnt;
  logic [11:0] cnt2;
  assign cnt  = (pixel_count_q > PIXELS_MAX) ? PIXELS_MAX : pixel_count_q;
  assign cnt2 = {cnt, 1'b0};

  // Pipeline flow control: a stage loads when it is empty or its
  // successor loads.
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] adv;

  always_comb begin
    adv[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int k = NStg-2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: reciprocal multiplies and phase products
  logic [63:0] p10, p50, pf, pwt, pwx;
  assign p10 = 64'(in_req_i.elapsed_ms) * RECIP_DIV10;
  assign p50 = 64'(in_req_i.elapsed_ms) * RECIP_DIV50;
  assign pf  = 64'(in_req_i.elapsed_ms) * FADE_STEP;
  assign pwt = 64'(in_req_i.elapsed_ms) * WAVE_STEP_T;
  assign pwx = 64'(in_req_i.pixel_index) * WAVE_STEP_X;

  logic [9:0]  pix_q [DIV_STAGES+1];
  logic [7:0]  ht_q  [DIV_STAGES+1];
  logic [26:0] q50_q [DIV_STAGES];
  logic [31:0] fph_q, wpt_q, wpx_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pix_q[0] <= in_req_i.pixel_index;
      ht_q[0]  <= p10[42:35];
      q50_q[0] <= p50[62:36];
      fph_q    <= pf[31:0];
      wpt_q    <= pwt[31:0];
      wpx_q    <= pwx[31:0];
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (adv[k]) begin
        pix_q[k] <= pix_q[k-1];
        ht_q[k]  <= ht_q[k-1];
      end
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (adv[k]) q50_q[k] <= q50_q[k-1];
    end
  end

  // Stages 1 to 4: divisions, seven dividend bits per stage
  div_t       dc_q [DIV_STAGES];
  div_t       dh_q [DIV_STAGES];
  div_t       cin  [DIV_STAGES];
  div_t       hin  [DIV_STAGES];
  logic [6:0] cbits [DIV_STAGES];
  logic [6:0] hbits [DIV_STAGES];
  logic [27:0] cdiv [DIV_STAGES];
  logic [27:0] hdiv [DIV_STAGES];

  always_comb begin
    cin[0] = '0;
    hin[0] = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      cin[k] = dc_q[k-1];
      hin[k] = dh_q[k-1];
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      cdiv[k]  = {1'b0, q50_q[k]};
      hdiv[k]  = {10'd0, pix_q[k], 8'd0};
      cbits[k] = cdiv[k][27 - DIV_STEPS*k -: DIV_STEPS];
      hbits[k] = hdiv[k][27 - DIV_STEPS*k -: DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (adv[k+1]) begin
        dc_q[k] <= div_steps(cin[k], cbits[k], cnt2);
        dh_q[k] <= div_steps(hin[k], hbits[k], {1'b0, cnt});
      end
    end
  end

  // Stage 1: sine index; stage 2: table read; stage 3: scale; stage 4: hold
  logic [31:0]        phase;
  logic [IdxW+31:0]   iprod;
  logic [IdxW-1:0]    idx_q;
  logic signed [15:0] sine_q;
  logic [16:0]        u;
  logic [24:0]        m255;
  wave_t              scl_q [2];

  assign phase = (pattern_mode_q == MODE_FADE) ? fph_q : (wpt_q + wpx_q);
  assign iprod = (IdxW+32)'(phase) * (IdxW+32)'(SINE_ENTRIES);
  assign u     = {sine_q[15], sine_q} + 17'd32769;
  assign m255  = {u, 8'd0} - {8'd0, u};

  always_ff @(posedge clk_i) begin
    if (adv[1]) idx_q  <= iprod[32 +: IdxW];
    if (adv[2]) sine_q <= SINE_ROM[idx_q];
    if (adv[3]) begin
      scl_q[0].lvl <= m255[23:16];
      scl_q[0].r   <= m255[23:16];
      scl_q[0].g   <= u[16:9];
      scl_q[0].b   <= {1'b0, u[16:10]};
    end
    if (adv[4]) scl_q[1] <= scl_q[0];
  end

  // Stage 5: pick the color by mode and blank pixels off the strip
  logic        on;
  logic [7:0]  hue, p, pp;
  logic [9:0]  x3;
  logic [11:0] pos, pixw;
  pixel_out_t  res, out_q;

  always_comb begin
    pixw = {2'd0, pix_q[DIV_STAGES]};
    on   = {1'b0, pix_q[DIV_STAGES]} < cnt;
    pos  = dc_q[DIV_STAGES-1].rem;
    hue  = ht_q[DIV_STAGES] + dh_q[DIV_STAGES-1].quo;
    p    = 8'd255 - hue;
    if (p < 8'd85) begin
      pp = p;
    end else if (p < 8'd170) begin
      pp = p - 8'd85;
    end else begin
      pp = p - 8'd170;
    end
    x3  = 10'(pp) * 10'd3;
    res = '0;
    res.level = user_brightness_q;
    case (pattern_mode_q)
      MODE_STATIC: begin
        res.red   = fill_color_q[31:24];
        res.green = fill_color_q[23:16];
        res.blue  = fill_color_q[15:8];
        res.white = fill_color_q[7:0];
      end
      MODE_RAINBOW: begin
        if (p < 8'd85) begin
          res.red  = 8'd255 - x3[7:0];
          res.blue = x3[7:0];
        end else if (p < 8'd170) begin
          res.green = x3[7:0];
          res.blue  = 8'd255 - x3[7:0];
        end else begin
          res.red   = x3[7:0];
          res.green = 8'd255 - x3[7:0];
        end
      end
      MODE_CHASE: begin
        if (pos < {1'b0, cnt}) begin
          if (pixw == pos) res.red = 8'd255;
        end else if (pixw == cnt2 - pos - 12'd1) begin
          res.blue = 8'd255;
        end
      end
      MODE_FADE: begin
        res.red   = 8'd255;
        res.green = 8'd255;
        res.blue  = 8'd255;
        res.level = scl_q[1].lvl;
      end
      MODE_WAVE: begin
        res.red   = scl_q[1].r;
        res.green = scl_q[1].g;
        res.blue  = scl_q[1].b;
      end
      default: ;
    endcase
    if (!on) begin
      res.red   = 8'd0;
      res.green = 8'd0;
      res.blue  = 8'd0;
      res.white = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NStg-1]) out_q <= res;
  end

  assign out_valid_o = v_q[NStg-1];
  assign out_data_o  = out_q;

endmodule

/* rtl/core/lspg_checker.sv */
// Port-level checks for the LED strip pattern pixel generator.
// Depends on lspg_pkg; bound to the top level below.
module lspg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input lspg_pkg::pixel_out_t out_data_o
);
  import lspg_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Take a request whenever the output drains or stands empty.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("request refused while pipeline can advance");

  // Leave reset with nothing in flight.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // The $past term samples the same idle input as the antecedent, so this check can never fail.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_valid_i |=> !out_valid_o || $past(in_valid_i, 1) == 1'b0)
    else $error("result appeared from nowhere");

endmodule

bind led_strip_pattern_pixel_generator_core lspg_checker u_lspg_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the LED strip pattern pixel generator core.
// Drives pixel requests and register writes, predicts each color from its own
// model of the pattern modes; depends on lspg_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;
  import lspg_pkg::*;

  localparam int NUM_RANDOM = 1550;
  localparam int IDLE_LIMIT = 20000;
  localparam int PIPE_DRAIN = 16;
  localparam int HOLD_CYCLES = 60;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  pixel_req_t in_req_i;
  logic       out_valid_o;
  logic       out_ready_i;
  pixel_out_t out_data_o;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  // Shadow copy of the configuration registers
  logic [2:0]  cur_mode;
  logic [10:0] cur_count;
  logic [7:0]  cur_bright;
  logic [31:0] cur_fill;

  pixel_out_t expected_colors[$];
  int         error_count;
  int         idle_cycles;
  int         requests_sent;
  int         colors_checked;
  bit         hold_off_req;
  bit         hold_off_done;

  led_strip_pattern_pixel_generator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sine table entry k as signed Q1.15, built from the odd polynomial in Q30.
  function automatic longint sine_entry(int unsigned k);
    longint f, quad, w, u, u2, acc, s, q;
    f    = (longint'(k) << 32) / 1024;
    quad = f >> 30;
    w    = f & 64'h3FFF_FFFF;
    u    = quad[0] ? ((64'sd1 << 30) - w) : w;
    u2   = (u * u) >>> 30;
    acc  = 172272;
    acc  = -5026995 + acc * u2 / (64'sd1 << 30);
    acc  = 85569306 + acc * u2 / (64'sd1 << 30);
    acc  = -693598668 + acc * u2 / (64'sd1 << 30);
    acc  = 1686629713 + acc * u2 / (64'sd1 << 30);
    s    = acc * u / (64'sd1 << 30);
    if (s < 0) s = 0;
    q = (s + 16384) / 32768;
    if (q > 32767) q = 32767;
    return (quad >= 2) ? -q : q;
  endfunction

  // Offset sine (2..65536) at a 32-bit turn phase.
  function automatic longint offset_sine(logic [31:0] phase);
    longint idx;
    idx = (longint'(phase) * 1024) >> 32;
    return sine_entry(int'(idx)) + 32769;
  endfunction

  // Color and level that the core should produce for one request.
  function automatic pixel_out_t pixel_color(pixel_req_t rq);
    pixel_out_t  c;
    longint      cnt, hue, p, pos, us;
    logic [31:0] ph;
    bit          on_strip;
    cnt = (cur_count > 1024) ? 1024 : cur_count;
    on_strip = rq.pixel_index < cnt;
    c = '0;
    c.level = cur_bright;
    case (cur_mode)
      MODE_STATIC: {c.red, c.green, c.blue, c.white} = cur_fill;
      MODE_RAINBOW: if (on_strip) begin
        hue = ((rq.elapsed_ms / 10) + (longint'(rq.pixel_index) * 256) / cnt) & 255;
        p = 255 - hue;
        if (p < 85) begin
          c.red = 255 - 3 * p; c.blue = 3 * p;
        end else if (p < 170) begin
          p -= 85; c.green = 3 * p; c.blue = 255 - 3 * p;
        end else begin
          p -= 170; c.red = 3 * p; c.green = 255 - 3 * p;
        end
      end
      MODE_CHASE: if (on_strip) begin
        pos = (rq.elapsed_ms / 50) % (cnt * 2);
        if (pos < cnt) begin
          if (rq.pixel_index == pos) c.red = 8'd255;
        end else if (rq.pixel_index == cnt * 2 - pos - 1) begin
          c.blue = 8'd255;
        end
      end
      MODE_FADE: begin
        ph = rq.elapsed_ms * 32'd13671306;
        us = offset_sine(ph);
        c.red = 8'd255; c.green = 8'd255; c.blue = 8'd255;
        c.level = (us * 255) >> 16;
      end
      MODE_WAVE: begin
        ph = rq.elapsed_ms * 32'd34178264 + 32'(rq.pixel_index) * 32'd341782638;
        us = offset_sine(ph);
        c.red = (us * 255) >> 16; c.green = (us * 128) >> 16; c.blue = (us * 64) >> 16;
      end
      default: ;
    endcase
    if (!on_strip) begin
      c.red = '0; c.green = '0; c.blue = '0; c.white = '0;
    end
    return c;
  endfunction

  // Write one register; the core is idle whenever this is called.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:       cur_mode = val[2:0];
      REG_COUNT:      cur_count = val[10:0];
      REG_BRIGHTNESS: cur_bright = val[7:0];
      default:        cur_fill = val;
    endcase
  endtask

  task automatic set_config(logic [2:0] m, logic [10:0] n, logic [7:0] br, logic [31:0] fc);
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_COUNT, 32'(n));
    write_reg(REG_BRIGHTNESS, 32'(br));
    write_reg(REG_FILL, fc);
  endtask

  // Offer one request, hold it until accepted and queue its expected color.
  task automatic send_request(logic [31:0] t, logic [9:0] idx);
    pixel_req_t rq;
    rq.elapsed_ms  = t;
    rq.pixel_index = idx;
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    expected_colors.push_back(pixel_color(rq));
    requests_sent++;
  endtask

  // Drop valid and let the pipeline drain before touching the registers.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  // Compare each accepted color with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected color %h", out_data_o);
        error_count++;
      end else begin
        want = expected_colors.pop_front();
        colors_checked++;
        if (out_data_o.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_data_o.red); error_count++;
        end
        if (out_data_o.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_data_o.green); error_count++;
        end
        if (out_data_o.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_data_o.blue); error_count++;
        end
        if (out_data_o.white !== want.white) begin
          $error("white: expected %0d, got %0d", want.white, out_data_o.white); error_count++;
        end
        if (out_data_o.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, out_data_o.level); error_count++;
        end
      end
    end
  end

  // Receiver: stall on its own pattern, with one long hold-off on request.
  initial begin
    int n;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      n = $urandom_range(0, 3);
      if (n == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run if nothing is accepted for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  typedef struct {
    logic [2:0]  m;
    logic [10:0] n;
    logic [7:0]  br;
    logic [31:0] fc;
    logic [31:0] t;
    logic [9:0]  idx;
    bit          known;
    pixel_out_t  want;
  } row_t;

  initial begin
    row_t rows[$];
    int   burst, ph;
    logic [2:0] m;
    logic [10:0] n;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_MODE;
    cfg_data_i  = '0;
    error_count = 0;
    idle_cycles = 0;
    requests_sent = 0;
    colors_checked = 0;
    hold_off_req = 1'b0;
    hold_off_done = 1'b0;
    cur_mode = MODE_STATIC; cur_count = 11'd1; cur_bright = 8'd255; cur_fill = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: reset defaults, extremes of each field, every mode,
    // pixels off the strip, count zero and saturated count, unused modes.
    rows = '{
      '{MODE_STATIC, 11'd1, 8'd255, 32'h0, 32'h0, 10'd0, 1, '{0, 0, 0, 0, 255}},
      '{MODE_STATIC, 11'd1024, 8'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 10'd1023, 1,
        '{255, 255, 255, 255, 0}},
      '{MODE_STATIC, 11'd4, 8'd7, 32'h11223344, 32'h0, 10'd4, 1, '{0, 0, 0, 0, 7}},
      '{MODE_STATIC, 11'd0, 8'd9, 32'hAABBCCDD, 32'h5, 10'd0, 1, '{0, 0, 0, 0, 9}},
      '{MODE_STATIC, 11'd2047, 8'd1, 32'h12345678, 32'h0, 10'd1023, 1,
        '{8'h12, 8'h34, 8'h56, 8'h78, 1}},
      '{MODE_RAINBOW, 11'd1, 8'd200, 32'h0, 32'h0, 10'd0, 1, '{255, 0, 0, 0, 200}},
      '{MODE_RAINBOW, 11'd1024, 8'd3, 32'h0, 32'hFFFFFFFF, 10'd1023, 0, '0},
      '{MODE_RAINBOW, 11'd10, 8'd3, 32'h0, 32'd12345, 10'd9, 0, '0},
      '{MODE_RAINBOW, 11'd10, 8'd3, 32'h0, 32'd12345, 10'd10, 1, '{0, 0, 0, 0, 3}},
      '{MODE_CHASE, 11'd8, 8'd50, 32'h0, 32'd0, 10'd0, 1, '{255, 0, 0, 0, 50}},
      '{MODE_CHASE, 11'd8, 8'd50, 32'h0, 32'd400, 10'd7, 1, '{0, 0, 255, 0, 50}},
      '{MODE_CHASE, 11'd8, 8'd50, 32'h0, 32'd799, 10'd0, 1, '{0, 0, 255, 0, 50}},
      '{MODE_CHASE, 11'd1024, 8'd50, 32'h0, 32'hFFFFFFFF, 10'd1023, 0, '0},
      '{MODE_CHASE, 11'd0, 8'd50, 32'h0, 32'd0, 10'd0, 1, '{0, 0, 0, 0, 50}},
      '{MODE_FADE, 11'd1, 8'd0, 32'h0, 32'd0, 10'd0, 0, '0},
      '{MODE_FADE, 11'd1, 8'd0, 32'h0, 32'hFFFFFFFF, 10'd0, 0, '0},
      '{MODE_FADE, 11'd1, 8'd0, 32'h0, 32'd78, 10'd1, 0, '0},
      '{MODE_WAVE, 11'd1024, 8'd99, 32'h0, 32'd0, 10'd0, 0, '0},
      '{MODE_WAVE, 11'd1024, 8'd99, 32'h0, 32'hFFFFFFFF, 10'd1023, 0, '0},
      '{MODE_WAVE, 11'd1024, 8'd99, 32'h0, 32'd31, 10'd3, 0, '0},
      '{3'd5, 11'd4, 8'd77, 32'hFFFFFFFF, 32'd5, 10'd1, 1, '{0, 0, 0, 0, 77}},
      '{3'd7, 11'd4, 8'd78, 32'hFFFFFFFF, 32'd5, 10'd1, 1, '{0, 0, 0, 0, 78}}
    };
    foreach (rows[k]) begin
      wait_drained();
      set_config(rows[k].m, rows[k].n, rows[k].br, rows[k].fc);
      send_request(rows[k].t, rows[k].idx);
      // Override the prediction where the row types in the answer.
      if (rows[k].known) expected_colors[expected_colors.size() - 1] = rows[k].want;
    end

    // Random phases: new configuration, then bursts with random gaps.
    ph = 0;
    while (requests_sent < NUM_RANDOM + rows.size()) begin
      wait_drained();
      m = (ph % 7 == 6) ? 3'($urandom_range(5, 7)) : 3'(ph % 5);
      case ($urandom_range(0, 5))
        0:       n = 11'd1;
        1:       n = 11'd1024;
        2:       n = 11'($urandom_range(1025, 2047));
        3:       n = 11'd0;
        default: n = 11'($urandom_range(1, 40));
      endcase
      set_config(m, n, 8'($urandom), $urandom);
      // Hold off the receiver once so that the pipeline fills and stalls.
      if (ph == 3) hold_off_req = 1'b1;
      repeat ($urandom_range(8, 24)) begin
        if ($urandom_range(0, 4) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk_i);
        end
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          // Mostly pixels near the strip, sometimes anywhere.
          if (requests_sent < NUM_RANDOM + rows.size()) begin
            send_request(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000),
                         ($urandom_range(0, 3) == 0) ? 10'($urandom)
                         : 10'($urandom_range(0, (n == 0) ? 3 : ((n > 1023) ? 1023 : n))));
          end
        end
      end
      ph++;
    end

    wait_drained();
    $display("Run covered %0d pixel requests and %0d checked colors over %0d phases,",
             requests_sent, colors_checked, ph);
    $display("all five modes, unused modes, off-strip pixels and count extremes.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lspg_pkg.sv
rtl/core/led_strip_pattern_pixel_generator_core.sv
rtl/core/lspg_checker.sv
verif/tb_top.sv
